[sv/sps_pkg.sv]
// Shared types, codes and helper functions for the stepper phase sequencer.
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

    localparam int OP_W     = 3;
    localparam int PERIOD_W = 24;
    localparam int STATUS_W = 3;
    localparam int COIL_W   = 4;
    localparam int TABLE_W  = 32;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef logic [OP_W-1:0]     t_opcode;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [COIL_W-1:0]   t_coils;

    localparam t_opcode OP_TICK       = 3'd0;
    localparam t_opcode OP_STOP       = 3'd1;
    localparam t_opcode OP_POWER_DOWN = 3'd2;
    localparam t_opcode OP_MOVE_TO    = 3'd3;
    localparam t_opcode OP_UNHOME     = 3'd4;
    localparam t_opcode OP_HOME_MIN   = 3'd5;
    localparam t_opcode OP_HOME_MAX   = 3'd6;
    localparam t_opcode OP_STATUS     = 3'd7;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_CLAMP_LOW   = 3'd1;
    localparam t_status ST_CLAMP_HIGH  = 3'd2;
    localparam t_status ST_UNHOMED     = 3'd3;
    localparam t_status ST_MAX_NO_MIN  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COUNT = 1'b1;

    localparam logic [TABLE_W-1:0] PHASE_TABLE_RESET = 32'h98C4_6231;
    localparam logic [COUNT_W-1:0] PHASE_COUNT_RESET = 4'd8;

    // Coil pattern for one phase: nibble idx of the packed table.
    function automatic t_coils phase_pattern(input logic [TABLE_W-1:0] tbl,
                                             input logic [2:0] idx);
        phase_pattern = tbl[{idx, 2'b00} +: COIL_W];
    endfunction

    // Phase count as used: zero counts as one, and it never exceeds the maximum.
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] cnt,
                                                     input logic [COUNT_W-1:0] max_cnt);
        if (cnt == '0) begin
            eff_count = COUNT_W'(1);
        end else if (cnt > max_cnt) begin
            eff_count = max_cnt;
        end else begin
            eff_count = cnt;
        end
    endfunction

endpackage

`default_nettype wire

[sv/sps_if.sv]
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none

interface sps_cmd_if #(
    parameter int POS_BITS = 24
) ();
    import sps_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            opcode;
    logic signed [POS_BITS-1:0] target_position;
    logic [PERIOD_W-1:0]        step_period;

    modport source(output valid, output opcode, output target_position,
                   output step_period, input ready);
    modport sink(input valid, input opcode, input target_position,
                 input step_period, output ready);
endinterface

interface sps_res_if #(
    parameter int POS_BITS = 24
) ();
    import sps_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [COIL_W-1:0]          coils;
    logic [PERIOD_W-1:0]        step_delay;
    logic                       moving;
    logic                       move_began;
    logic                       move_ended;
    logic signed [POS_BITS-1:0] position;
    logic signed [POS_BITS-1:0] target;
    logic                       homed_low;
    logic                       homed_high;
    logic [POS_BITS-2:0]        upper_limit;
    logic [POS_BITS-3:0]        mid_point;
    logic [STATUS_W-1:0]        status;

    modport source(output valid, output coils, output step_delay, output moving,
                   output move_began, output move_ended, output position,
                   output target, output homed_low, output homed_high,
                   output upper_limit, output mid_point, output status,
                   input ready);
    modport sink(input valid, input coils, input step_delay, input moving,
                 input move_began, input move_ended, input position,
                 input target, input homed_low, input homed_high,
                 input upper_limit, input mid_point, input status,
                 output ready);
endinterface

`default_nettype wire

[sv/sps_step.sv]
// Motor state registers and the single-pass update logic for one command.
`timescale 1ns / 1ps
`default_nettype none

module sps_step #(
    parameter int MAX_PHASES = 8,
    parameter int POS_BITS   = 24
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_adv,
    input  wire [sps_pkg::OP_W-1:0]          i_op,
    input  wire signed [POS_BITS-1:0]        i_tgt,
    input  wire [sps_pkg::PERIOD_W-1:0]      i_per,
    input  wire [sps_pkg::TABLE_W-1:0]       i_phase_table,
    input  wire [sps_pkg::COUNT_W-1:0]       i_phase_count,
    output logic [sps_pkg::COIL_W-1:0]       o_coils,
    output logic [sps_pkg::PERIOD_W-1:0]     o_step_delay,
    output logic                             o_moving,
    output logic                             o_move_began,
    output logic                             o_move_ended,
    output logic signed [POS_BITS-1:0]       o_position,
    output logic signed [POS_BITS-1:0]       o_target,
    output logic                             o_homed_low,
    output logic                             o_homed_high,
    output logic [POS_BITS-2:0]              o_upper_limit,
    output logic [POS_BITS-3:0]              o_mid_point,
    output logic [sps_pkg::STATUS_W-1:0]     o_status
);
    import sps_pkg::*;

    localparam int PIW = $clog2(MAX_PHASES);
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_PHASES);

    logic signed [POS_BITS-1:0] r_cur,  n_cur;
    logic signed [POS_BITS-1:0] r_goal, n_goal;
    logic [PERIOD_W-1:0]        r_per_goal, n_per_goal;
    logic [PERIOD_W-1:0]        r_per_now,  n_per_now;
    logic                       r_low_homed,  n_low_homed;
    logic                       r_high_homed, n_high_homed;
    logic [POS_BITS-2:0]        r_max_lim, n_max_lim;
    logic [POS_BITS-3:0]        r_center,  n_center;
    logic [PIW-1:0]             r_phase,   n_phase;
    logic                       r_motion,  n_motion;
    logic [COIL_W-1:0]          r_coils,   n_coils;
    logic                       r_began,   n_began;
    logic                       r_ended,   n_ended;
    t_status                    r_status,  n_status;

    logic [COUNT_W-1:0]         w_cnt;
    logic [COUNT_W-1:0]         w_phase_ext;
    logic signed [POS_BITS-1:0] w_max_signed;

    assign w_cnt        = eff_count(i_phase_count, MAX_CNT);
    assign w_phase_ext  = COUNT_W'(r_phase);
    assign w_max_signed = $signed({1'b0, r_max_lim});

    always_comb begin
        n_cur        = r_cur;
        n_goal       = r_goal;
        n_per_goal   = r_per_goal;
        n_per_now    = r_per_now;
        n_low_homed  = r_low_homed;
        n_high_homed = r_high_homed;
        n_max_lim    = r_max_lim;
        n_center     = r_center;
        n_phase      = r_phase;
        n_motion     = r_motion;
        n_coils      = r_coils;
        n_began      = 1'b0;
        n_ended      = 1'b0;
        n_status     = ST_OK;

        case (i_op)
            OP_TICK: begin
                if (r_motion) begin
                    n_per_now = r_per_goal;
                    if (r_goal < r_cur) begin
                        // Stepping backwards wraps to the last phase in use.
                        if (r_phase == '0 || w_phase_ext >= w_cnt) begin
                            n_phase = PIW'(w_cnt - COUNT_W'(1));
                        end else begin
                            n_phase = r_phase - PIW'(1);
                        end
                        n_cur   = r_cur - POS_BITS'(1);
                        n_coils = phase_pattern(i_phase_table, 3'(n_phase));
                    end else if (r_goal > r_cur) begin
                        if (w_phase_ext + COUNT_W'(1) >= w_cnt) begin
                            n_phase = '0;
                        end else begin
                            n_phase = r_phase + PIW'(1);
                        end
                        n_cur   = r_cur + POS_BITS'(1);
                        n_coils = phase_pattern(i_phase_table, 3'(n_phase));
                    end else begin
                        n_motion = 1'b0;
                        n_coils  = '0;
                        n_ended  = 1'b1;
                    end
                end
            end
            OP_STOP: begin
                n_goal    = r_cur;
                n_per_now = '0;
            end
            OP_POWER_DOWN: begin
                n_coils = '0;
            end
            OP_MOVE_TO: begin
                n_per_goal = i_per;
                n_goal     = i_tgt;
                if (r_low_homed && r_high_homed) begin
                    if (i_tgt < 0) begin
                        n_goal   = '0;
                        n_status = ST_CLAMP_LOW;
                    end else if (i_tgt > w_max_signed) begin
                        n_goal   = w_max_signed;
                        n_status = ST_CLAMP_HIGH;
                    end
                end else begin
                    n_status = ST_UNHOMED;
                end
                n_motion = 1'b1;
                n_began  = 1'b1;
            end
            OP_UNHOME: begin
                n_low_homed  = 1'b0;
                n_high_homed = 1'b0;
                n_max_lim    = '0;
            end
            OP_HOME_MIN: begin
                n_coils     = '0;
                n_ended     = 1'b1;
                n_low_homed = 1'b1;
                n_cur       = '0;
                n_goal      = '0;
            end
            OP_HOME_MAX: begin
                n_coils = '0;
                n_ended = 1'b1;
                if (r_low_homed) begin
                    n_high_homed = 1'b1;
                    // A negative position saturates the limit at zero.
                    n_max_lim    = r_cur[POS_BITS-1] ? '0 : r_cur[POS_BITS-2:0];
                    n_center     = n_max_lim[POS_BITS-2:1];
                    n_goal       = '0;
                end else begin
                    n_status = ST_MAX_NO_MIN;
                end
            end
            OP_STATUS: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur        <= '0;
            r_goal       <= '0;
            r_per_goal   <= '0;
            r_per_now    <= '0;
            r_low_homed  <= 1'b0;
            r_high_homed <= 1'b0;
            r_max_lim    <= '0;
            r_center     <= '0;
            r_phase      <= '0;
            r_motion     <= 1'b0;
            r_coils      <= '0;
            r_began      <= 1'b0;
            r_ended      <= 1'b0;
            r_status     <= ST_OK;
        end else if (i_adv) begin
            r_cur        <= n_cur;
            r_goal       <= n_goal;
            r_per_goal   <= n_per_goal;
            r_per_now    <= n_per_now;
            r_low_homed  <= n_low_homed;
            r_high_homed <= n_high_homed;
            r_max_lim    <= n_max_lim;
            r_center     <= n_center;
            r_phase      <= n_phase;
            r_motion     <= n_motion;
            r_coils      <= n_coils;
            r_began      <= n_began;
            r_ended      <= n_ended;
            r_status     <= n_status;
        end
    end

    // The state registers double as the result register: they only change
    // when a transaction is handed on, so a stalled result holds.
    assign o_coils       = r_coils;
    assign o_step_delay  = r_motion ? r_per_now : '0;
    assign o_moving      = r_motion;
    assign o_move_began  = r_began;
    assign o_move_ended  = r_ended;
    assign o_position    = r_cur;
    assign o_target      = r_goal;
    assign o_homed_low   = r_low_homed;
    assign o_homed_high  = r_high_homed;
    assign o_upper_limit = r_max_lim;
    assign o_mid_point   = r_center;
    assign o_status      = r_status;

endmodule

`default_nettype wire

[sv/stepper_phase_sequencer_homing.sv]
// Top level of the stepper phase sequencer with homing.
//
//  Port      Dir  Handshake     Carries
//  i_cmd     in   valid/ready   opcode, target_position, step_period
//  o_res     out  valid/ready   coils, step delay, motion flags, position, homing status
//  i_cfg_*   in   write enable  phase_table (index 0), phase_count (index 1)
//
// Each command passes an input register and then the update logic into the
// state/result registers, and while the output is not stalled one transaction
// is taken every cycle. Reset clears all state and loads the default phase
// table and count. A stall at the output holds the result and lets one more
// command wait in the input register before ready falls.
`timescale 1ns / 1ps
`default_nettype none

module stepper_phase_sequencer_homing #(
    parameter int MAX_PHASES = 8,
    parameter int POS_BITS   = 24
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [sps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [sps_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    sps_cmd_if.sink                            i_cmd,
    sps_res_if.source                          o_res
);
    import sps_pkg::*;

    logic                       r_in_vld;
    t_opcode                    r_op;
    logic signed [POS_BITS-1:0] r_tgt;
    logic [PERIOD_W-1:0]        r_per;
    logic                       r_res_vld;
    logic [TABLE_W-1:0]         r_phase_table;
    logic [COUNT_W-1:0]         r_phase_count;
    logic                       w_adv;
    logic                       w_take;

    assign w_adv       = r_in_vld && (!r_res_vld || o_res.ready);
    assign i_cmd.ready = !r_in_vld || w_adv;
    assign w_take      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_res_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op  <= i_cmd.opcode;
            r_tgt <= i_cmd.target_position;
            r_per <= i_cmd.step_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_table <= PHASE_TABLE_RESET;
            r_phase_count <= PHASE_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PHASE_TABLE: r_phase_table <= i_cfg_data;
                CFG_PHASE_COUNT: r_phase_count <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sps_step #(
        .MAX_PHASES (MAX_PHASES),
        .POS_BITS   (POS_BITS)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_op          (r_op),
        .i_tgt         (r_tgt),
        .i_per         (r_per),
        .i_phase_table (r_phase_table),
        .i_phase_count (r_phase_count),
        .o_coils       (o_res.coils),
        .o_step_delay  (o_res.step_delay),
        .o_moving      (o_res.moving),
        .o_move_began  (o_res.move_began),
        .o_move_ended  (o_res.move_ended),
        .o_position    (o_res.position),
        .o_target      (o_res.target),
        .o_homed_low   (o_res.homed_low),
        .o_homed_high  (o_res.homed_high),
        .o_upper_limit (o_res.upper_limit),
        .o_mid_point   (o_res.mid_point),
        .o_status      (o_res.status)
    );

    assign o_res.valid = r_res_vld;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the stepper phase sequencer with homing.
`timescale 1ns / 1ps

module tb;
    import sps_pkg::*;

    typedef struct packed {
        t_coils             coils;
        logic [23:0]        step_delay;
        logic               moving;
        logic               move_began;
        logic               move_ended;
        logic signed [23:0] position;
        logic signed [23:0] target;
        logic               homed_low;
        logic               homed_high;
        logic [22:0]        upper_limit;
        logic [21:0]        mid_point;
        t_status            status;
    } t_motor_report;

    typedef struct {
        t_motor_report rep;
        bit            pinned;
        t_status       pin_status;
        logic [23:0]   pin_pos;
        logic [23:0]   pin_tgt;
    } t_pending_report;

    typedef struct {
        t_opcode     op;
        logic [23:0] tgt;
        logic [23:0] per;
        bit          pinned;
        t_status     st;
        logic [23:0] pos;
        logic [23:0] tgt_exp;
    } t_cmd_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sps_cmd_if #(.POS_BITS(24)) cmd_if ();
    sps_res_if #(.POS_BITS(24)) res_if ();

    stepper_phase_sequencer_homing #(
        .MAX_PHASES(8),
        .POS_BITS  (24)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (cmd_if),
        .o_res     (res_if)
    );

    // Shadow copy of the sequencer state and its registers.
    logic [31:0]        m_table;
    logic [3:0]         m_count;
    logic signed [23:0] m_pos;
    logic signed [23:0] m_goal;
    logic [23:0]        m_per_goal;
    logic [23:0]        m_per_now;
    bit                 m_lo;
    bit                 m_hi;
    logic [22:0]        m_lim;
    logic [21:0]        m_ctr;
    logic [2:0]         m_phase;
    bit                 m_motion;
    t_coils             m_coil;

    t_pending_report pending_reports[$];
    t_cmd_row        directed_rows[$];

    int  mismatches;
    bit  gaps_on;
    bit  hold_req;

    bit          drv_pinned;
    t_status     drv_pin_status;
    logic [23:0] drv_pin_pos;
    logic [23:0] drv_pin_tgt;

    t_pending_report acc_entry;
    t_pending_report want_entry;
    t_motor_report   got_rep;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic step_motor(input t_opcode op, input logic signed [23:0] tp,
                              input logic [23:0] sp, output t_motor_report r);
        int                 cnt;
        logic signed [23:0] t;
        bit                 began;
        bit                 ended;
        t_status            st;
        began = 1'b0;
        ended = 1'b0;
        st    = ST_OK;
        case (op)
            OP_TICK: begin
                if (m_motion) begin
                    cnt = (m_count == 4'd0) ? 1 : ((m_count > 4'd8) ? 8 : int'(m_count));
                    m_per_now = m_per_goal;
                    if (m_goal < m_pos) begin
                        if (m_phase == 3'd0 || int'(m_phase) >= cnt) begin
                            m_phase = 3'(cnt - 1);
                        end else begin
                            m_phase = m_phase - 3'd1;
                        end
                        m_pos = m_pos - 24'sd1;
                    end else if (m_goal > m_pos) begin
                        if (int'(m_phase) + 1 >= cnt) begin
                            m_phase = 3'd0;
                        end else begin
                            m_phase = m_phase + 3'd1;
                        end
                        m_pos = m_pos + 24'sd1;
                    end else begin
                        m_motion = 1'b0;
                        m_coil   = '0;
                        ended    = 1'b1;
                    end
                    if (m_motion) begin
                        m_coil = m_table[int'(m_phase) * 4 +: 4];
                    end
                end
            end
            OP_STOP: begin
                m_goal    = m_pos;
                m_per_now = '0;
            end
            OP_POWER_DOWN: begin
                m_coil = '0;
            end
            OP_MOVE_TO: begin
                t          = tp;
                m_per_goal = sp;
                if (m_lo && m_hi) begin
                    if (t < 0) begin
                        t  = '0;
                        st = ST_CLAMP_LOW;
                    end else if (t > $signed({1'b0, m_lim})) begin
                        t  = {1'b0, m_lim};
                        st = ST_CLAMP_HIGH;
                    end
                end else begin
                    st = ST_UNHOMED;
                end
                m_goal   = t;
                m_motion = 1'b1;
                began    = 1'b1;
            end
            OP_UNHOME: begin
                m_lo  = 1'b0;
                m_hi  = 1'b0;
                m_lim = '0;
            end
            OP_HOME_MIN: begin
                m_coil = '0;
                ended  = 1'b1;
                m_lo   = 1'b1;
                m_pos  = '0;
                m_goal = '0;
            end
            OP_HOME_MAX: begin
                m_coil = '0;
                ended  = 1'b1;
                if (m_lo) begin
                    m_hi   = 1'b1;
                    // A negative position leaves no range, so the limit saturates.
                    m_lim  = (m_pos < 0) ? 23'd0 : m_pos[22:0];
                    m_ctr  = m_lim[22:1];
                    m_goal = '0;
                end else begin
                    st = ST_MAX_NO_MIN;
                end
            end
            default: begin
            end
        endcase
        r.coils       = m_coil;
        r.step_delay  = m_motion ? m_per_now : 24'd0;
        r.moving      = m_motion;
        r.move_began  = began;
        r.move_ended  = ended;
        r.position    = m_pos;
        r.target      = m_goal;
        r.homed_low   = m_lo;
        r.homed_high  = m_hi;
        r.upper_limit = m_lim;
        r.mid_point   = m_ctr;
        r.status      = st;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 10) begin
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
            end
            mismatches++;
        end
    endtask

    task automatic compare_report(input t_pending_report w, input t_motor_report g);
        check_field("coils", w.rep.coils, g.coils);
        check_field("step_delay", w.rep.step_delay, g.step_delay);
        check_field("moving", w.rep.moving, g.moving);
        check_field("move_began", w.rep.move_began, g.move_began);
        check_field("move_ended", w.rep.move_ended, g.move_ended);
        check_field("position", w.rep.position, g.position);
        check_field("target", w.rep.target, g.target);
        check_field("homed_low", w.rep.homed_low, g.homed_low);
        check_field("homed_high", w.rep.homed_high, g.homed_high);
        check_field("upper_limit", w.rep.upper_limit, g.upper_limit);
        check_field("mid_point", w.rep.mid_point, g.mid_point);
        check_field("status", w.rep.status, g.status);
        if (w.pinned) begin
            check_field("status (table)", w.pin_status, g.status);
            check_field("position (table)", w.pin_pos, $unsigned(g.position));
            check_field("target (table)", w.pin_tgt, $unsigned(g.target));
        end
    endtask

    // Commands are predicted as they are accepted; results are checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                step_motor(cmd_if.opcode, cmd_if.target_position, cmd_if.step_period,
                           acc_entry.rep);
                acc_entry.pinned     = drv_pinned;
                acc_entry.pin_status = drv_pin_status;
                acc_entry.pin_pos    = drv_pin_pos;
                acc_entry.pin_tgt    = drv_pin_tgt;
                pending_reports.push_back(acc_entry);
            end
            if (res_if.valid && res_if.ready) begin
                got_rep = '{res_if.coils, res_if.step_delay, res_if.moving,
                            res_if.move_began, res_if.move_ended, res_if.position,
                            res_if.target, res_if.homed_low, res_if.homed_high,
                            res_if.upper_limit, res_if.mid_point, res_if.status};
                if (pending_reports.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result transaction with nothing expected: %0h", got_rep);
                    end
                    mismatches++;
                end else begin
                    want_entry = pending_reports.pop_front();
                    compare_report(want_entry, got_rep);
                end
            end
        end
    end

    // Result side: random back-pressure, with one long hold-off on request.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                res_if.ready = 1'b0;
            end else if (hold_req) begin
                res_if.ready = 1'b0;
                repeat (60) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                res_if.ready = !gaps_on || ($urandom_range(99) >= 20);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_PHASE_TABLE) begin
            m_table = data;
        end else begin
            m_count = data[3:0];
        end
    endtask

    task automatic send_cmd(input t_opcode op, input logic [23:0] tp,
                            input logic [23:0] sp, input bit pin,
                            input t_status pst, input logic [23:0] ppos,
                            input logic [23:0] ptgt);
        while (gaps_on && $urandom_range(99) < 20) begin
            cmd_if.valid           = 1'b0;
            cmd_if.opcode          = t_opcode'($urandom);
            cmd_if.target_position = 24'($urandom);
            cmd_if.step_period     = 24'($urandom);
            @(negedge i_clk);
        end
        cmd_if.valid           = 1'b1;
        cmd_if.opcode          = op;
        cmd_if.target_position = tp;
        cmd_if.step_period     = sp;
        drv_pinned             = pin;
        drv_pin_status         = pst;
        drv_pin_pos            = ppos;
        drv_pin_tgt            = ptgt;
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
    endtask

    // Let every expected result arrive, then let the pipeline settle.
    task automatic drain_results();
        cmd_if.valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic void add_row(input t_opcode op, input logic [23:0] tgt,
                                    input logic [23:0] per, input t_status st,
                                    input logic [23:0] pos, input logic [23:0] tgt_exp);
        t_cmd_row row;
        row.op      = op;
        row.tgt     = tgt;
        row.per     = per;
        row.pinned  = 1'b1;
        row.st      = st;
        row.pos     = pos;
        row.tgt_exp = tgt_exp;
        directed_rows.push_back(row);
    endfunction

    task automatic send_random_cmd();
        int          w;
        int          v;
        t_opcode     op;
        logic [23:0] tp;
        w = $urandom_range(99);
        if (w < 55)      op = OP_TICK;
        else if (w < 67) op = OP_MOVE_TO;
        else if (w < 71) op = OP_STOP;
        else if (w < 75) op = OP_POWER_DOWN;
        else if (w < 78) op = OP_UNHOME;
        else if (w < 85) op = OP_HOME_MIN;
        else if (w < 92) op = OP_HOME_MAX;
        else             op = OP_STATUS;
        // Most targets lie within 40 steps of the position so that moves stay short.
        if ($urandom_range(9) == 0) begin
            tp = 24'($urandom);
        end else begin
            v  = m_pos;
            v  = v + int'($urandom_range(80)) - 40;
            tp = 24'(v);
        end
        send_cmd(op, tp, 24'($urandom), 1'b0, ST_OK, '0, '0);
    endtask

    initial begin
        int          cnt_pick[10];
        logic [31:0] tbl;

        cnt_pick = '{1, 8, 0, 15, 3, 5, 2, 7, 4, 6};
        mismatches = 0;
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        drv_pinned = 1'b0;
        drv_pin_status = ST_OK;
        drv_pin_pos    = '0;
        drv_pin_tgt    = '0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        cmd_if.valid           = 1'b0;
        cmd_if.opcode          = OP_TICK;
        cmd_if.target_position = '0;
        cmd_if.step_period     = '0;

        m_table    = PHASE_TABLE_RESET;
        m_count    = PHASE_COUNT_RESET;
        m_pos      = '0;
        m_goal     = '0;
        m_per_goal = '0;
        m_per_now  = '0;
        m_lo       = 1'b0;
        m_hi       = 1'b0;
        m_lim      = '0;
        m_ctr      = '0;
        m_phase    = '0;
        m_motion   = 1'b0;
        m_coil     = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Walk through homing, unhoming, clamping, power-down and the stop and retarget cases.
        add_row(OP_STATUS,     24'h000000, 24'h000000, ST_OK,         24'h000000, 24'h000000);
        add_row(OP_TICK,       24'h7FFFFF, 24'hFFFFFF, ST_OK,         24'h000000, 24'h000000);
        add_row(OP_HOME_MAX,   24'h000000, 24'h000000, ST_MAX_NO_MIN, 24'h000000, 24'h000000);
        add_row(OP_MOVE_TO,    24'h000003, 24'hFFFFFF, ST_UNHOMED,    24'h000000, 24'h000003);
        add_row(OP_TICK,       24'h000000, 24'h000000, ST_OK,         24'h000001, 24'h000003);
        add_row(OP_TICK,       24'h000000, 24'h000000, ST_OK,         24'h000002, 24'h000003);
        add_row(OP_TICK,       24'h000000, 24'h000000, ST_OK,         24'h000003, 24'h000003);
        add_row(OP_TICK,       24'h000000, 24'h000000, ST_OK,         24'h000003, 24'h000003);
        add_row(OP_MOVE_TO,    24'h800000, 24'h000000, ST_UNHOMED,    24'h000003, 24'h800000);
        add_row(OP_TICK,       24'h000000, 24'h000000, ST_OK,         24'h000002, 24'h800000);
        add_row(OP_STOP,       24'h000000, 24'h000000, ST_OK,         24'h000002, 24'h000002);
        add_row(OP_TICK,       24'h000000, 24'h000000, ST_OK,         24'h000002, 24'h000002);
        add_row(OP_POWER_DOWN, 24'h000000, 24'h000000, ST_OK,         24'h000002, 24'h000002);
        add_row(OP_HOME_MIN,   24'h000000, 24'h000000, ST_OK,         24'h000000, 24'h000000);
        add_row(OP_MOVE_TO,    24'h000002, 24'h000005, ST_UNHOMED,    24'h000000, 24'h000002);
        add_row(OP_TICK,       24'h000000, 24'h000000, ST_OK,         24'h000001, 24'h000002);
        add_row(OP_TICK,       24'h000000, 24'h000000, ST_OK,         24'h000002, 24'h000002);
        add_row(OP_HOME_MAX,   24'h000000, 24'h000000, ST_OK,         24'h000002, 24'h000000);
        add_row(OP_MOVE_TO,    24'hFFFFFF, 24'h000007, ST_CLAMP_LOW,  24'h000002, 24'h000000);
        add_row(OP_MOVE_TO,    24'h7FFFFF, 24'h000009, ST_CLAMP_HIGH, 24'h000002, 24'h000002);
        add_row(OP_TICK,       24'h000000, 24'h000000, ST_OK,         24'h000002, 24'h000002);
        add_row(OP_UNHOME,     24'h000000, 24'h000000, ST_OK,         24'h000002, 24'h000002);
        add_row(OP_HOME_MIN,   24'h000000, 24'h000000, ST_OK,         24'h000000, 24'h000000);
        add_row(OP_MOVE_TO,    24'hFFFFFB, 24'h000003, ST_UNHOMED,    24'h000000, 24'hFFFFFB);
        add_row(OP_TICK,       24'h000000, 24'h000000, ST_OK,         24'hFFFFFF, 24'hFFFFFB);
        add_row(OP_HOME_MAX,   24'h000000, 24'h000000, ST_OK,         24'hFFFFFF, 24'h000000);

        write_reg(CFG_PHASE_TABLE, PHASE_TABLE_RESET);
        write_reg(CFG_PHASE_COUNT, 32'(PHASE_COUNT_RESET));
        foreach (directed_rows[i]) begin
            send_cmd(directed_rows[i].op, directed_rows[i].tgt, directed_rows[i].per,
                     directed_rows[i].pinned, directed_rows[i].st, directed_rows[i].pos,
                     directed_rows[i].tgt_exp);
        end
        drain_results();

        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 1)      tbl = 32'h0000_0000;
            else if (ph == 2) tbl = 32'hFFFF_FFFF;
            else              tbl = $urandom;
            write_reg(CFG_PHASE_TABLE, tbl);
            // Upper data bits are noise; only the low nibble holds the count.
            write_reg(CFG_PHASE_COUNT, {28'($urandom), 4'(cnt_pick[ph])});
            gaps_on = (ph != 5);
            for (int n = 0; n < 100; n++) begin
                if (ph == 3 && n == 30) begin
                    hold_req = 1'b1;
                end
                send_random_cmd();
            end
            drain_results();
        end
        gaps_on = 1'b1;

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
